[sv/lru_write_back_block_cache_core_defines.svh]
// Assertion helpers shared by the cache core.
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_CORE_DEFINES_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbc check failed");

// Next-cycle implication, checked outside reset.
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbc check failed");

`endif

[sv/lbc_pkg.sv]
package lbc_pkg;

  localparam int ACTION_W = 2;
  localparam int BLOCK_W  = 24;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int ADDR_W   = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET  = 2'd0,
    ACT_MARK = 2'd1,
    ACT_SYNC = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    K_HIT    = 3'd0,
    K_WB     = 3'd1,
    K_FILL   = 3'd2,
    K_MARKED = 3'd3,
    K_ABSENT = 3'd4,
    K_DONE   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_LOOKUP,
    FS_DECIDE,
    FS_FILL,
    FS_SYNC,
    FS_DONE
  } front_state_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } res_ctl_t;

  localparam int CTL_W = $bits(res_ctl_t);

endpackage

[sv/lbc_in_if.sv]
interface lbc_in_if;
  import lbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BLOCK_W-1:0]  block_number;

  modport src (output valid, action, block_number, input ready);
  modport snk (input valid, action, block_number, output ready);
endinterface

[sv/lbc_out_if.sv]
interface lbc_out_if;
  import lbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] device_address;
  logic              last;

  modport src (output valid, kind, slot, device_address, last, input ready);
  modport snk (input valid, kind, slot, device_address, last, output ready);
endinterface

[sv/lbc_fifo.sv]
module lbc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end
endmodule

[sv/lbc_front.sv]
module lbc_front #(
  parameter int ENTRIES    = 16,
  parameter int BLOCK_BITS = 24,
  parameter int SW         = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  lbc_in_if.snk                   in_ch,
  output logic                    res_push,
  input  logic                    res_full,
  output lbc_pkg::res_ctl_t       res_ctl,
  output logic [SW-1:0]           res_slot,
  output logic [BLOCK_BITS-1:0]   res_tag
);
  import lbc_pkg::*;

  localparam logic [SW-1:0] LAST_RANK = SW'(ENTRIES - 1);

  front_state_t          state_r, state_nxt;
  action_t               act_r, act_nxt;
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;
  logic [ENTRIES-1:0]    hit_oh_r, hit_oh_nxt;
  logic [ENTRIES-1:0]    vic_oh_r, vic_oh_nxt;
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [ENTRIES-1:0]    dirty_r, dirty_nxt;
  logic [SW-1:0]         rank_r [ENTRIES];
  logic [SW-1:0]         rank_nxt [ENTRIES];
  logic [BLOCK_BITS-1:0] tag_r [ENTRIES];

  logic [ENTRIES-1:0]    sync_oh;
  logic [ENTRIES-1:0]    sel_oh;
  logic [SW-1:0]         sel_idx;
  logic [SW-1:0]         sel_rank;
  logic [BLOCK_BITS-1:0] sel_tag;
  logic                  sel_wb;
  logic                  hit_any;
  logic                  do_recent;
  logic                  tag_we;

  assign hit_any = |hit_oh_r;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      sync_oh[i] = (rank_r[i] == cnt_r);
    end
  end

  // The selected slot is always a one-hot vector, so its fields are an AND-OR.
  always_comb begin
    if (state_r == FS_SYNC) begin
      sel_oh = sync_oh;
    end else if (hit_any) begin
      sel_oh = hit_oh_r;
    end else begin
      sel_oh = vic_oh_r;
    end
    sel_idx  = '0;
    sel_rank = '0;
    sel_tag  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_oh[i]) begin
        sel_idx  = sel_idx | SW'(i);
        sel_rank = sel_rank | rank_r[i];
        sel_tag  = sel_tag | tag_r[i];
      end
    end
    sel_wb = |(sel_oh & valid_r & dirty_r);
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    blk_nxt      = blk_r;
    cnt_nxt      = cnt_r;
    hit_oh_nxt   = hit_oh_r;
    vic_oh_nxt   = vic_oh_r;
    valid_nxt    = valid_r;
    dirty_nxt    = dirty_r;
    in_ch.ready  = 1'b0;
    res_push     = 1'b0;
    res_ctl.kind = K_HIT;
    res_ctl.last = 1'b1;
    res_slot     = sel_idx;
    res_tag      = blk_r;
    do_recent    = 1'b0;
    tag_we       = 1'b0;

    case (state_r)
      FS_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          act_nxt = action_t'(in_ch.action);
          blk_nxt = BLOCK_BITS'(in_ch.block_number);
          cnt_nxt = '0;
          case (action_t'(in_ch.action))
            ACT_GET:  state_nxt = FS_LOOKUP;
            ACT_MARK: state_nxt = FS_LOOKUP;
            ACT_SYNC: state_nxt = FS_SYNC;
            default:  state_nxt = FS_IDLE;
          endcase
        end
      end
      FS_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          hit_oh_nxt[i] = valid_r[i] && (tag_r[i] == blk_r);
          vic_oh_nxt[i] = (rank_r[i] == LAST_RANK);
        end
        state_nxt = FS_DECIDE;
      end
      FS_DECIDE: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (act_r == ACT_MARK) begin
            state_nxt = FS_IDLE;
            if (hit_any) begin
              res_ctl.kind = K_MARKED;
              dirty_nxt    = dirty_r | hit_oh_r;
            end else begin
              res_ctl.kind = K_ABSENT;
              res_slot     = '0;
            end
          end else if (hit_any) begin
            res_ctl.kind = K_HIT;
            do_recent    = 1'b1;
            state_nxt    = FS_IDLE;
          end else if (sel_wb) begin
            // Dirty victim: its write-back goes out before the fill.
            res_ctl.kind = K_WB;
            res_ctl.last = 1'b0;
            res_tag      = sel_tag;
            state_nxt    = FS_FILL;
          end else begin
            res_ctl.kind = K_FILL;
            tag_we       = 1'b1;
            valid_nxt    = valid_r | sel_oh;
            dirty_nxt    = dirty_r & ~sel_oh;
            do_recent    = 1'b1;
            state_nxt    = FS_IDLE;
          end
        end
      end
      FS_FILL: begin
        if (!res_full) begin
          res_push     = 1'b1;
          res_ctl.kind = K_FILL;
          tag_we       = 1'b1;
          valid_nxt    = valid_r | sel_oh;
          dirty_nxt    = dirty_r & ~sel_oh;
          do_recent    = 1'b1;
          state_nxt    = FS_IDLE;
        end
      end
      FS_SYNC: begin
        res_ctl.kind = K_WB;
        res_ctl.last = 1'b0;
        res_tag      = sel_tag;
        if (!sel_wb || !res_full) begin
          if (sel_wb) begin
            res_push  = 1'b1;
            dirty_nxt = dirty_r & ~sel_oh;
          end
          if (cnt_r == LAST_RANK) begin
            state_nxt = FS_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      FS_DONE: begin
        if (!res_full) begin
          res_push     = 1'b1;
          res_ctl.kind = K_DONE;
          res_slot     = '0;
          state_nxt    = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  // Move the selected slot to the front; younger slots age by one.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_recent) begin
        if (sel_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (rank_r[i] < sel_rank) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      valid_r <= '0;
      dirty_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= SW'(ENTRIES - 1 - i);
      end
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    blk_r    <= blk_nxt;
    cnt_r    <= cnt_nxt;
    hit_oh_r <= hit_oh_nxt;
    vic_oh_r <= vic_oh_nxt;
    if (tag_we) begin
      tag_r[sel_idx] <= blk_r;
    end
  end
endmodule

[sv/lbc_back.sv]
module lbc_back #(
  parameter int BLOCK_BITS = 24,
  parameter int SW         = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lbc_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  lbc_pkg::res_ctl_t            q_ctl,
  input  logic [SW-1:0]                q_slot,
  input  logic [BLOCK_BITS-1:0]        q_tag,
  lbc_out_if.src                       out_ch
);
  import lbc_pkg::*;

  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              valid_r, valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              last_r, last_nxt;

  assign q_pop = !q_empty && (!valid_r || out_ch.ready);

  always_comb begin
    base_nxt  = cfg_wr_en ? cfg_wr_data : base_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    slot_nxt  = slot_r;
    addr_nxt  = addr_r;
    last_nxt  = last_r;
    if (valid_r && out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (q_pop) begin
      valid_nxt = 1'b1;
      kind_nxt  = q_ctl.kind;
      slot_nxt  = SLOT_W'(q_slot);
      last_nxt  = q_ctl.last;
      if (q_ctl.kind == K_WB || q_ctl.kind == K_FILL) begin
        addr_nxt = ADDR_W'(q_tag) + base_r;
      end else begin
        addr_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      base_r  <= base_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    slot_r <= slot_nxt;
    addr_r <= addr_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.slot           = slot_r;
  assign out_ch.device_address = addr_r;
  assign out_ch.last           = last_r;
endmodule

[sv/lru_write_back_block_cache_core.sv]
// Tag, dirty and LRU manager for a fully associative block cache. One request is
// taken at a time: the front sequencer holds the tags and recency ranks in
// flip-flops, compares all slots in parallel and queues at most one result per
// cycle, while the queue has room, into a two-entry queue; the back end adds the
// base address and holds each result in an output register. A get or mark-dirty
// request passes the accept, compare and decide steps, a get that must first write
// back a dirty victim adds a fill step, and a sync walks one recency rank per cycle,
// waiting on a dirty slot while the queue is full. A stalled output stalls the
// front only once the queue is full. Action code 3 is accepted and dropped.
// base_address may only be written while no request is in flight.
module lru_write_back_block_cache_core #(
  parameter int ENTRIES    = 16,
  parameter int BLOCK_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [lbc_pkg::ADDR_W-1:0] cfg_wr_data,
  lbc_in_if.snk                      in_ch,
  lbc_out_if.src                     out_ch
);
  import lbc_pkg::*;
  `include "lru_write_back_block_cache_core_defines.svh"

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW = CTL_W + SW + BLOCK_BITS;

  logic                  q_push, q_full, q_pop, q_empty;
  res_ctl_t              f_ctl, q_ctl;
  logic [SW-1:0]         f_slot, q_slot;
  logic [BLOCK_BITS-1:0] f_tag, q_tag;
  logic [QW-1:0]         q_wr_data, q_rd_data;
  logic                  acc_work;

  lbc_front #(
    .ENTRIES    (ENTRIES),
    .BLOCK_BITS (BLOCK_BITS),
    .SW         (SW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .res_push (q_push),
    .res_full (q_full),
    .res_ctl  (f_ctl),
    .res_slot (f_slot),
    .res_tag  (f_tag)
  );

  assign q_wr_data = {f_ctl, f_slot, f_tag};

  lbc_fifo #(
    .W     (QW),
    .DEPTH (2)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign q_ctl  = res_ctl_t'(q_rd_data[QW-1 -: CTL_W]);
  assign q_slot = q_rd_data[BLOCK_BITS +: SW];
  assign q_tag  = q_rd_data[BLOCK_BITS-1:0];

  lbc_back #(
    .BLOCK_BITS (BLOCK_BITS),
    .SW         (SW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_ctl       (q_ctl),
    .q_slot      (q_slot),
    .q_tag       (q_tag),
    .out_ch      (out_ch)
  );

  // The unused action code is dropped in the accepting cycle, so only real work busies the front.
  assign acc_work = in_ch.valid && in_ch.ready && (action_t'(in_ch.action) != ACT_NONE);

  `LBC_ASSERT_NOW(a_no_push_full, clk, rst_n, q_push, !q_full)
  `LBC_ASSERT_NOW(a_no_pop_empty, clk, rst_n, q_pop, !q_empty)
  `LBC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, acc_work, !in_ch.ready)
endmodule

[tb/lru_write_back_block_cache_core_tb.sv]
module lru_write_back_block_cache_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbc_pkg::*;

  localparam int ENTRIES       = 16;
  localparam int POOL_SIZE     = 20;
  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int LONG_HOLD     = 80;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  device_address;
    logic               last;
  } cache_result_t;

  typedef struct {
    action_t            act;
    logic [BLOCK_W-1:0] blk;
    bit                 typed;
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  addr;
    bit                 rebase;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [ADDR_W-1:0] cfg_wr_data;

  lbc_in_if  in_ch ();
  lbc_out_if out_ch ();

  lru_write_back_block_cache_core #(
    .ENTRIES   (ENTRIES),
    .BLOCK_BITS(BLOCK_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the cache bookkeeping.
  logic [BLOCK_W-1:0] tag_of [ENTRIES];
  bit                 slot_valid [ENTRIES];
  bit                 slot_dirty [ENTRIES];
  int unsigned        age_rank [ENTRIES];
  logic [ADDR_W-1:0]  cur_base;

  cache_result_t      expected_q[$];
  logic [BLOCK_W-1:0] block_pool [POOL_SIZE];

  bit            row_typed;
  cache_result_t row_expect;
  int            src_idle_pct;
  int            sink_idle_pct;
  bit            long_hold_go;

  int errors;
  int n_requests;
  int n_results;
  int n_writebacks;
  int n_hits;
  int cycle_count;

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    if (errors < 50)
      $display("MISMATCH at request %0d: %s got 0x%0h expected 0x%0h",
               n_requests, what, got, want);
    errors++;
  endtask

  function automatic int lookup_slot(input logic [BLOCK_W-1:0] blk);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && tag_of[i] == blk) return i;
    return -1;
  endfunction

  function automatic int slot_at_rank(input int unsigned r);
    for (int i = 0; i < ENTRIES; i++)
      if (age_rank[i] == r) return i;
    return 0;
  endfunction

  function automatic void promote(input int s);
    int unsigned r;
    r = age_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (age_rank[i] < r) age_rank[i]++;
    age_rank[s] = 0;
  endfunction

  function automatic void push_result(input kind_t k, input int s,
                                      input logic [ADDR_W-1:0] addr, input logic last);
    cache_result_t r;
    r.kind = k;
    r.slot = SLOT_W'(s);
    r.device_address = addr;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_results(input action_t act, input logic [BLOCK_W-1:0] blk);
    int s;
    case (act)
      ACT_GET: begin
        s = lookup_slot(blk);
        if (s >= 0) begin
          promote(s);
          push_result(K_HIT, s, '0, 1'b1);
        end else begin
          s = slot_at_rank(ENTRIES - 1);
          if (slot_valid[s] && slot_dirty[s])
            push_result(K_WB, s, ADDR_W'(tag_of[s]) + cur_base, 1'b0);
          slot_dirty[s] = 1'b0;
          tag_of[s] = blk;
          slot_valid[s] = 1'b1;
          promote(s);
          push_result(K_FILL, s, ADDR_W'(blk) + cur_base, 1'b1);
        end
      end
      ACT_MARK: begin
        s = lookup_slot(blk);
        if (s >= 0) begin
          slot_dirty[s] = 1'b1;
          push_result(K_MARKED, s, '0, 1'b1);
        end else begin
          push_result(K_ABSENT, 0, '0, 1'b1);
        end
      end
      ACT_SYNC: begin
        for (int r = 0; r < ENTRIES; r++) begin
          s = slot_at_rank(r);
          if (slot_valid[s] && slot_dirty[s]) begin
            push_result(K_WB, s, ADDR_W'(tag_of[s]) + cur_base, 1'b0);
            slot_dirty[s] = 1'b0;
          end
        end
        push_result(K_DONE, 0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Handshakes are sampled mid-cycle; inputs only change at rising edges.
  always @(negedge clk) begin
    cache_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (out_ch.kind == K_WB) n_writebacks++;
        if (out_ch.kind == K_HIT) n_hits++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending, kind", ADDR_W'(out_ch.kind), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", ADDR_W'(out_ch.kind), ADDR_W'(want.kind));
          if (out_ch.slot !== want.slot)
            report_mismatch("slot", ADDR_W'(out_ch.slot), ADDR_W'(want.slot));
          if (out_ch.device_address !== want.device_address)
            report_mismatch("device_address", out_ch.device_address, want.device_address);
          if (out_ch.last !== want.last)
            report_mismatch("last", ADDR_W'(out_ch.last), ADDR_W'(want.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        n_requests++;
        predict_results(action_t'(in_ch.action), in_ch.block_number);
        if (row_typed) begin
          void'(expected_q.pop_back());
          expected_q.push_back(row_expect);
        end
      end
    end
  end

  // Result receiver; a long hold is counted here once requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        hold_left = LONG_HOLD;
        long_hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input action_t act, input logic [BLOCK_W-1:0] blk);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.block_number <= blk;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stops offering requests until every pending result is back and the core is quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cur_base = value;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) block_pool[i] = BLOCK_W'($urandom);
  endfunction

  // A pool a little larger than the cache gives a mix of hits, evictions and misses.
  task automatic random_burst(input int count);
    int issued;
    int pick;
    action_t act;
    logic [BLOCK_W-1:0] blk;
    issued = 0;
    while (issued < count) begin
      pick = $urandom_range(99);
      blk = block_pool[$urandom_range(POOL_SIZE - 1)];
      if (pick < 60) begin
        act = ACT_GET;
      end else if (pick < 85) begin
        act = ACT_MARK;
      end else if (pick < 90) begin
        act = ACT_SYNC;
        blk = BLOCK_W'($urandom);
      end else if (pick < 95) begin
        act = pick[0] ? ACT_GET : ACT_MARK;
        blk = BLOCK_W'($urandom);
      end else begin
        act = ACT_NONE;
        blk = BLOCK_W'($urandom);
      end
      send_request(act, blk);
      if (act != ACT_NONE) issued++;
    end
  endtask

  initial begin
    probe_row_t probe_rows[$];
    probe_row_t row;

    errors = 0;
    n_requests = 0;
    n_results = 0;
    n_writebacks = 0;
    n_hits = 0;
    cycle_count = 0;
    row_typed = 1'b0;
    long_hold_go = 1'b0;
    src_idle_pct = 29;
    sink_idle_pct = 77;
    cur_base = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_of[i] = '0;
      slot_valid[i] = 1'b0;
      slot_dirty[i] = 1'b0;
      age_rank[i] = ENTRIES - 1 - i;
    end

    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_GET;
    in_ch.block_number <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // From reset: empty cache, slot 0 least recent, base address zero.
    probe_rows.push_back('{ACT_MARK, 24'h000000, 1'b1, K_ABSENT, 4'd0, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_SYNC, 24'h000000, 1'b1, K_DONE, 4'd0, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_GET, 24'h000000, 1'b1, K_FILL, 4'd0, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_GET, 24'hFFFFFF, 1'b1, K_FILL, 4'd1, 32'h00FF_FFFF, 1'b0});
    probe_rows.push_back('{ACT_GET, 24'h000000, 1'b1, K_HIT, 4'd0, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_MARK, 24'hFFFFFF, 1'b1, K_MARKED, 4'd1, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_MARK, 24'h000000, 1'b1, K_MARKED, 4'd0, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_NONE, 24'h5A5A5A, 1'b0, K_HIT, 4'd0, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_SYNC, 24'hA5A5A5, 1'b0, K_HIT, 4'd0, 32'h0, 1'b0});
    // All-ones base: addresses wrap. Fill the rest, then evict the dirty slot 1.
    probe_rows.push_back('{ACT_MARK, 24'hFFFFFF, 1'b1, K_MARKED, 4'd1, 32'h0, 1'b1});
    for (int i = 2; i < ENTRIES; i++)
      probe_rows.push_back('{ACT_GET, BLOCK_W'(i), 1'b0, K_HIT, 4'd0, 32'h0, 1'b0});
    probe_rows.push_back('{ACT_GET, 24'h000010, 1'b0, K_HIT, 4'd0, 32'h0, 1'b0});

    foreach (probe_rows[i]) begin
      row = probe_rows[i];
      if (row.rebase) begin
        settle();
        write_base(32'hFFFF_FFFF);
      end
      row_typed = row.typed;
      row_expect = '{kind: row.kind, slot: row.slot, device_address: row.addr, last: 1'b1};
      send_request(row.act, row.blk);
    end
    row_typed = 1'b0;

    settle();
    write_base(ADDR_W'($urandom));
    refresh_pool();
    random_burst(60);

    settle();
    src_idle_pct = 77;
    sink_idle_pct = 29;
    write_base(ADDR_W'($urandom));
    refresh_pool();
    random_burst(60);

    // No idling; the receiver stalls for a long stretch while requests keep coming.
    settle();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_base(32'h0);
    refresh_pool();
    long_hold_go = 1'b1;
    random_burst(20);
    settle();
    write_base(ADDR_W'($urandom));
    random_burst(40);

    settle();
    $display("Sent %0d requests over several base addresses; checked %0d results",
             n_requests, n_results);
    $display("including %0d write-backs and %0d hits, with a long output stall",
             n_writebacks, n_hits);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
